// File: design/msbac_pkg.sv
package msbac_pkg;

  // Widths of the payload fields and of the occurrence counters.
  localparam int ValueW = 16;
  localparam int CountW = 16;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef logic [ValueW-1:0] value_t;
  typedef logic [CountW-1:0] count_t;

  // One entry of the distinct value table.
  typedef struct packed {
    value_t value;
    count_t count;
  } tbl_entry_t;

endpackage

// File: design/multiset_bin_assignment_check.sv
// Checks whether a multiset of numbers can serve a list of customers, each
// customer taking its whole quantity from items of one single value. A
// transaction with cmd = 0 adds a customer quantity, and one with cmd = 1 adds
// a number, which is looked up in a table of distinct values one entry at a
// time, with a read state and a compare state per entry. A quantity is
// taken in the idle state itself. On a transaction with last set, the
// block first sums the quantities for every customer subset, clears one row
// of the reachability table, and then walks, for every distinct value, every
// mask and its submasks through one shared compare unit, with a read state
// and a compare state per step (at most 3^m steps per distinct value for m
// customers, after its count is fetched). One result transaction follows,
// and the input is stalled for the whole of that work. overflow reports
// customers, distinct values or counts that were lost since the previous
// result.
module multiset_bin_assignment_check #(
  parameter int MAX_CUSTOMERS = 10,
  parameter int MAX_DISTINCT  = 64,
  parameter int VALUE_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  msbac_pkg::value_t     value,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  feasible,
  output logic                  overflow
);
  import msbac_pkg::*;

  localparam int MW = MAX_CUSTOMERS;
  localparam int IW = $clog2(MAX_CUSTOMERS + 1);
  localparam int QW = (MAX_CUSTOMERS > 1) ? $clog2(MAX_CUSTOMERS) : 1;
  localparam int AW = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
  localparam int DW = $clog2(MAX_DISTINCT + 1);
  localparam int SW = ValueW + IW;
  localparam value_t VMASK = (VALUE_BITS >= ValueW) ? {ValueW{1'b1}} :
                             value_t'((64'd1 << VALUE_BITS) - 64'd1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SEARCH = 4'd1;
  localparam logic [3:0] ST_CMP    = 4'd2;
  localparam logic [3:0] ST_BUILD  = 4'd3;
  localparam logic [3:0] ST_INIT   = 4'd4;
  localparam logic [3:0] ST_DPK    = 4'd5;
  localparam logic [3:0] ST_DPC    = 4'd6;
  localparam logic [3:0] ST_DPI    = 4'd7;
  localparam logic [3:0] ST_DPE    = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;
  localparam logic [3:0] ST_FIN2   = 4'd10;

  logic [3:0]    st;
  logic [IW-1:0] cust_used;
  logic [DW-1:0] dist_used;
  logic          ovf;
  logic          last_q;
  value_t        num;
  value_t        cq [MAX_CUSTOMERS];

  logic [DW-1:0] k;
  logic [MW-1:0] mask;
  logic [MW-1:0] sub;
  logic [IW-1:0] bi;
  logic [SW-1:0] acc;
  count_t        cnt;
  logic          r;
  logic          cur;

  tbl_entry_t    tbl [MAX_DISTINCT];
  tbl_entry_t    tbl_q;
  logic [AW-1:0] tbl_ra;
  logic          tbl_we;
  logic [AW-1:0] tbl_wa;
  tbl_entry_t    tbl_wd;

  logic [SW-1:0] req [2**MW];
  logic [SW-1:0] req_q;
  logic          req_we;

  logic          reach [2**(MW+1)];
  logic          reach_q;
  logic [MW:0]   reach_ra;
  logic          reach_we;
  logic [MW:0]   reach_wa;
  logic          reach_wd;

  logic [MW-1:0] full;
  logic          hit;
  logic          rr;
  value_t        vin;

  assign in_stall = (st != ST_IDLE);
  assign full = ~({MW{1'b1}} << cust_used);
  assign vin = value & VMASK;
  assign hit = (req_q <= SW'(cnt)) && reach_q;
  assign rr = r | hit;

  always_comb begin
    tbl_ra = k[AW-1:0];
    reach_ra = {cur, mask ^ sub};
    if (st == ST_FIN || st == ST_FIN2) begin
      reach_ra = {cur, full};
    end
    tbl_we = 1'b0;
    tbl_wa = k[AW-1:0];
    tbl_wd = '{value: num, count: tbl_q.count + 1'b1};
    reach_we = 1'b0;
    reach_wa = {~cur, mask};
    reach_wd = rr;
    req_we = (st == ST_BUILD) && (bi == cust_used);
    case (st)
      ST_SEARCH: begin
        if (k == dist_used && dist_used < DW'(MAX_DISTINCT)) begin
          tbl_we = 1'b1;
          tbl_wa = dist_used[AW-1:0];
          tbl_wd = '{value: num, count: count_t'(1)};
        end
      end
      ST_CMP: begin
        tbl_we = (tbl_q.value == num) && (tbl_q.count != CountMax);
      end
      ST_INIT: begin
        reach_we = 1'b1;
        reach_wa = {1'b0, mask};
        reach_wd = (mask == '0);
      end
      ST_DPE: begin
        reach_we = rr || (sub == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tbl_q <= tbl[tbl_ra];
    if (tbl_we) begin
      tbl[tbl_wa] <= tbl_wd;
    end
    req_q <= req[sub];
    if (req_we) begin
      req[mask] <= acc;
    end
    reach_q <= reach[reach_ra];
    if (reach_we) begin
      reach[reach_wa] <= reach_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      cust_used <= '0;
      dist_used <= '0;
      ovf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && st != ST_FIN2) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (in_valid) begin
            num <= vin;
            last_q <= last;
            mask <= '0;
            bi <= '0;
            acc <= '0;
            k <= '0;
            if (cmd) begin
              st <= ST_SEARCH;
            end else begin
              if (cust_used < IW'(MAX_CUSTOMERS)) begin
                cq[cust_used[QW-1:0]] <= vin;
                cust_used <= cust_used + 1'b1;
              end else begin
                ovf <= 1'b1;
              end
              st <= last ? ST_BUILD : ST_IDLE;
            end
          end
        end
        ST_SEARCH: begin
          if (k == dist_used) begin
            if (dist_used < DW'(MAX_DISTINCT)) begin
              dist_used <= dist_used + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            st <= last_q ? ST_BUILD : ST_IDLE;
          end else begin
            st <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (tbl_q.value == num) begin
            if (tbl_q.count == CountMax) begin
              ovf <= 1'b1;
            end
            st <= last_q ? ST_BUILD : ST_IDLE;
          end else begin
            k <= k + 1'b1;
            st <= ST_SEARCH;
          end
        end
        ST_BUILD: begin
          // The subset sum of the current mask is accumulated one customer
          // per cycle and written when every customer bit has been looked at.
          if (bi == cust_used) begin
            acc <= '0;
            bi <= '0;
            if (mask == full) begin
              mask <= '0;
              st <= ST_INIT;
            end else begin
              mask <= mask + 1'b1;
            end
          end else begin
            if (mask[bi[QW-1:0]]) begin
              acc <= acc + SW'(cq[bi[QW-1:0]]);
            end
            bi <= bi + 1'b1;
          end
        end
        ST_INIT: begin
          if (mask == full) begin
            k <= '0;
            cur <= 1'b0;
            st <= ST_DPK;
          end else begin
            mask <= mask + 1'b1;
          end
        end
        ST_DPK: begin
          st <= (k == dist_used) ? ST_FIN : ST_DPC;
        end
        ST_DPC: begin
          cnt <= tbl_q.count;
          mask <= '0;
          sub <= '0;
          r <= 1'b0;
          st <= ST_DPI;
        end
        ST_DPI: begin
          st <= ST_DPE;
        end
        ST_DPE: begin
          // The empty submask stands for keeping the mask already reached,
          // so the walk runs from the mask itself down to zero.
          if (rr || sub == '0) begin
            r <= 1'b0;
            if (mask == full) begin
              cur <= ~cur;
              k <= k + 1'b1;
              st <= ST_DPK;
            end else begin
              mask <= mask + 1'b1;
              sub <= mask + 1'b1;
              st <= ST_DPI;
            end
          end else begin
            sub <= (sub - 1'b1) & mask;
            st <= ST_DPI;
          end
        end
        ST_FIN: begin
          st <= ST_FIN2;
        end
        ST_FIN2: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            feasible <= reach_q;
            overflow <= ovf;
            cust_used <= '0;
            dist_used <= '0;
            ovf <= 1'b0;
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st) == ST_FIN2)
    else $error("result raised outside the final state");

  a_cust_bound: assert property (@(posedge clk) disable iff (rst)
    cust_used <= IW'(MAX_CUSTOMERS))
    else $error("customer count beyond capacity");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    dist_used <= DW'(MAX_DISTINCT))
    else $error("distinct count beyond capacity");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> cust_used == '0 && dist_used == '0 && !ovf)
    else $error("problem state not cleared after a result");

endmodule

// File: verif/tb_multiset_bin_assignment_check.sv
`timescale 1ns / 1ps

class assign_scoreboard;
  localparam int MaxCust = 10;
  localparam int MaxDist = 64;

  logic [15:0] quantities[$];
  logic [15:0] dist_vals[$];
  logic [15:0] dist_cnts[$];
  bit          lost;
  bit          expected_feas[$];
  bit          expected_ovf[$];
  int          errors;
  int          checked;
  int          n_feasible;
  int          n_overflow;

  function int pending();
    return expected_feas.size();
  endfunction

  function bit evaluate();
    int          m;
    int          full;
    int          sub;
    bit          r;
    longint      req[1024];
    bit [1023:0] cur;
    bit [1023:0] nxt;
    m = quantities.size();
    full = (1 << m) - 1;
    for (int mask = 0; mask <= full; mask++) begin
      req[mask] = 0;
      for (int i = 0; i < m; i++)
        if (mask[i]) req[mask] += quantities[i];
    end
    cur = '0;
    cur[0] = 1'b1;
    foreach (dist_cnts[k]) begin
      for (int mask = 0; mask <= full; mask++) begin
        r = cur[mask];
        sub = mask;
        while (sub > 0 && !r) begin
          if (req[sub] <= dist_cnts[k] && cur[mask ^ sub]) r = 1'b1;
          sub = (sub - 1) & mask;
        end
        nxt[mask] = r;
      end
      cur = nxt;
    end
    return cur[full];
  endfunction

  function void note(bit cmd, logic [15:0] val, bit last);
    bit hit;
    hit = 1'b0;
    if (cmd == 1'b0) begin
      if (quantities.size() < MaxCust) quantities.push_back(val);
      else lost = 1'b1;
    end else begin
      foreach (dist_vals[k]) begin
        if (!hit && dist_vals[k] == val) begin
          hit = 1'b1;
          if (dist_cnts[k] == 16'hFFFF) lost = 1'b1;
          else dist_cnts[k]++;
        end
      end
      if (!hit) begin
        if (dist_vals.size() < MaxDist) begin
          dist_vals.push_back(val);
          dist_cnts.push_back(16'd1);
        end else begin
          lost = 1'b1;
        end
      end
    end
    if (last) begin
      expected_feas.push_back(evaluate());
      expected_ovf.push_back(lost);
      quantities.delete();
      dist_vals.delete();
      dist_cnts.delete();
      lost = 1'b0;
    end
  endfunction

  function void check(bit feas, bit ovf);
    bit ef;
    bit eo;
    if (expected_feas.size() == 0) begin
      $error("result transaction with no expectation waiting");
      errors++;
      return;
    end
    ef = expected_feas.pop_front();
    eo = expected_ovf.pop_front();
    checked++;
    if (ef) n_feasible++;
    if (eo) n_overflow++;
    if (feas !== ef) begin
      $error("feasible: expected %0d, actual %0d", ef, feas);
      errors++;
    end
    if (ovf !== eo) begin
      $error("overflow: expected %0d, actual %0d", eo, ovf);
      errors++;
    end
  endfunction
endclass

module tb_multiset_bin_assignment_check;
  import msbac_pkg::*;

  localparam bit CmdQty = 1'b0;
  localparam bit CmdNum = 1'b1;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   cmd = CmdQty;
  value_t value = '0;
  logic   last = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   feasible;
  logic   overflow;

  assign_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  multiset_bin_assignment_check u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .value(value), .last(last), .out_valid(out_valid), .out_stall(out_stall),
    .feasible(feasible), .overflow(overflow)
  );

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note(cmd, value, last);
    if (!rst && out_valid && !out_stall) sb.check(feasible, overflow);
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt > 1) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      hold_cnt <= 0;
      out_stall <= !quiet && ($urandom_range(0, 99) < 11);
    end
  end

  task automatic send(bit c, logic [15:0] v, bit l);
    if (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    value <= v;
    last <= l;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One problem: m customers, numbers mostly built to cover them, then last.
  task automatic problem(int m, bit wide, bit qty_last);
    logic [15:0] qs[$];
    logic [15:0] ns[$];
    logic [15:0] pool[6];
    int          q;
    foreach (pool[i]) pool[i] = wide ? 16'($urandom) : 16'($urandom_range(0, 9));
    for (int i = 0; i < m; i++) begin
      q = wide && $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 5);
      qs.push_back(q[15:0]);
      q = q + $urandom_range(0, 2) - 1;
      if (q > 8) q = $urandom_range(0, 8);
      repeat (q) ns.push_back(pool[$urandom_range(0, 2)]);
    end
    repeat ($urandom_range(0, 3)) ns.push_back(pool[$urandom_range(0, 5)]);
    if (qty_last && qs.size() > 0) begin
      foreach (ns[i]) send(CmdNum, ns[i], 1'b0);
      foreach (qs[i]) send(CmdQty, qs[i], i == qs.size() - 1);
    end else begin
      if (ns.size() == 0) ns.push_back(pool[0]);
      while (qs.size() + ns.size() > 1) begin
        if (qs.size() > 0 && (ns.size() <= 1 || $urandom_range(0, 1)))
          send(CmdQty, qs.pop_front(), 1'b0);
        else
          send(CmdNum, ns.pop_front(), 1'b0);
      end
      send(CmdNum, ns[0], 1'b1);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: no customers, extremes of value, quantity zero, last on a quantity.
    send(CmdNum, 16'hFFFF, 1'b1);
    send(CmdQty, 16'h0000, 1'b1);
    send(CmdQty, 16'hFFFF, 1'b0);
    send(CmdNum, 16'h0000, 1'b1);
    send(CmdQty, 16'd2, 1'b0);
    send(CmdQty, 16'd1, 1'b0);
    send(CmdNum, 16'h5A5A, 1'b0);
    send(CmdNum, 16'h5A5A, 1'b0);
    send(CmdNum, 16'hA5A5, 1'b0);
    send(CmdQty, 16'd1, 1'b1);
    // Too many customers, with few distinct values to keep the walk short.
    for (int i = 0; i < 11; i++) send(CmdQty, 16'd1, 1'b0);
    for (int i = 0; i < 10; i++) send(CmdNum, 16'd3, 1'b0);
    send(CmdNum, 16'd4, 1'b1);
    // Table full: one more distinct value than the table holds.
    send(CmdQty, 16'd1, 1'b0);
    for (int i = 0; i < 65; i++) send(CmdNum, 16'(i * 997), i == 64);
    drain();

    // Receiver holds off while problems keep coming.
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 6; i++) problem($urandom_range(0, 3), 1'b0, 1'b0);
    drain();

    while (items_sent < 1550) begin
      if ($urandom_range(0, 40) == 0) drain();
      quiet = (items_sent > 900 && items_sent < 1200);
      problem($urandom_range(0, 9) == 0 ? $urandom_range(5, 6) : $urandom_range(0, 4),
              $urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0);
    end
    quiet = 1'b0;
    drain();
    repeat (50) @(posedge clk);

    $display("Checked %0d results (%0d feasible, %0d with overflow) from %0d items,",
             sb.checked, sb.n_feasible, sb.n_overflow, items_sent);
    $display("covering customer and table overflow, a long receiver hold-off and stalls.");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("status: fail");
    $finish;
  end
endmodule

// File: multiset_bin_assignment_check.f
design/msbac_pkg.sv
design/multiset_bin_assignment_check.sv
verif/tb_multiset_bin_assignment_check.sv
